// ===== rtl/sorted_list_insert_delete_assert.svh =====
// Assertion macros for the sorted list insert/delete block
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property, checked on every clock outside reset
`define SLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define SLID_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLID_ASSERT(label, prop, msg)
`define SLID_ASSERT_IMPL(label, ante, cons, msg)
`define SLID_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/slid_pkg.sv =====
// Shared types and constants for the sorted list insert/delete block
package slid_pkg;

  localparam int VAL_W = 32;
  localparam int OCC_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } slid_status_t;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic                    op_ins;
    logic                    op_del;
    logic signed [VAL_W-1:0] value;
  } slid_bcast_t;

endpackage

// ===== rtl/sorted_list_insert_delete.sv =====
// Top level: sorted store of signed values built as a row of compare/shift cells
// A result is valid in the output register in the cycle after its request is accepted.
// One request per cycle while in_stall is low; the whole row compares and shifts in the
//   accept cycle, and the delete match ripples through every cell in that same cycle.
// Reset (synchronous, active low) clears the count and the output valid; cell contents
//   stay undefined until written and are never read beyond the count.
`include "sorted_list_insert_delete_assert.svh"

module sorted_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [slid_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [slid_pkg::OCC_W-1:0]        out_occupancy,
  output logic signed [slid_pkg::VAL_W-1:0] out_smallest
);
  import slid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // stored value count
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // output register
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  slid_status_t            out_status_r;
  slid_status_t            status_nxt;
  logic [OCC_W-1:0]        out_occ_r;
  logic signed [VAL_W-1:0] out_small_r;
  logic signed [VAL_W-1:0] small_nxt;

  logic        accept;
  logic        full;
  logic        found;
  slid_bcast_t bcast;

  // cell row wiring
  logic signed [VAL_W-1:0] val_w      [CAPACITY];
  logic signed [VAL_W-1:0] val_nxt_w  [CAPACITY];
  logic signed [VAL_W-1:0] left_val_w [CAPACITY];
  logic signed [VAL_W-1:0] right_val_w[CAPACITY];
  logic                    left_ge_w  [CAPACITY];
  logic                    ge_w       [CAPACITY];
  logic                    valid_w    [CAPACITY];
  logic                    hit_w      [CAPACITY+1];

  // a new request enters when the output register is empty or being drained
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));

  // refused inserts never reach the cells
  assign bcast.op_ins = accept && (in_cmd == CMD_INSERT) && !full;
  assign bcast.op_del = accept && (in_cmd == CMD_DELETE);
  assign bcast.value  = in_value;

  assign hit_w[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign valid_w[g] = (CNT_W'(g) < count_r);

      // insert shifts right from the left neighbor; head cell has none
      if (g == 0) begin : g_head
        assign left_val_w[g] = '0;
        assign left_ge_w[g]  = 1'b0;
      end else begin : g_body
        assign left_val_w[g] = val_w[g-1];
        assign left_ge_w[g]  = ge_w[g-1];
      end

      // delete pulls from the right neighbor; the tail refills with its own value
      if (g == CAPACITY - 1) begin : g_tail
        assign right_val_w[g] = val_w[g];
      end else begin : g_mid
        assign right_val_w[g] = val_w[g+1];
      end

      slid_cell u_cell (
        .clk       (clk),
        .bcast     (bcast),
        .valid     (valid_w[g]),
        .left_val  (left_val_w[g]),
        .left_ge   (left_ge_w[g]),
        .right_val (right_val_w[g]),
        .hit_in    (hit_w[g]),
        .val       (val_w[g]),
        .val_nxt   (val_nxt_w[g]),
        .ge        (ge_w[g]),
        .hit_out   (hit_w[g+1])
      );
    end
  endgenerate

  assign found = hit_w[CAPACITY];

  // count update and status
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (accept) begin
      if (in_cmd == CMD_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
    end
  end

  // smallest is the head cell's next content, zero when the store empties
  assign small_nxt     = (count_nxt != '0) ? val_nxt_w[0] : '0;
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload loads only on accept, so a stalled result holds
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_occ_r    <= OCC_W'(count_nxt);
      out_small_r  <= small_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;
  assign out_smallest  = out_small_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SLID_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `SLID_ASSERT_NEXT(a_full_refused, accept && (in_cmd == CMD_INSERT) && full,
    (out_status_r == ST_FULL) && (count_r == $past(count_r)), "full insert not refused")
  `SLID_ASSERT_NEXT(a_insert_grows, accept && (in_cmd == CMD_INSERT) && !full,
    (out_status_r == ST_OK) && (count_r == $past(count_r) + CNT_W'(1)), "insert count slip")
  `SLID_ASSERT_IMPL(a_empty_zero, out_valid_r && (out_occ_r == '0),
    out_small_r == '0, "smallest not zero on empty store")

endmodule

// ===== rtl/slid_cell.sv =====
// One storage cell of the sorted row: compare, shift right on insert, shift left on delete
module slid_cell (
  input  logic                             clk,
  input  slid_pkg::slid_bcast_t            bcast,
  input  logic                             valid,
  input  logic signed [slid_pkg::VAL_W-1:0] left_val,
  input  logic                             left_ge,
  input  logic signed [slid_pkg::VAL_W-1:0] right_val,
  input  logic                             hit_in,
  output logic signed [slid_pkg::VAL_W-1:0] val,
  output logic signed [slid_pkg::VAL_W-1:0] val_nxt,
  output logic                             ge,
  output logic                             hit_out
);
  import slid_pkg::*;

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  // cell holds a value not below the request: insert point is here or left
  assign ge      = valid && (value_r >= bcast.value);
  // match seen here or anywhere to the left
  assign hit_out = hit_in || (valid && (value_r == bcast.value));

  always_comb begin
    value_nxt = value_r;
    if (bcast.op_ins) begin
      if (left_ge) begin
        value_nxt = left_val;
      end else if (!valid || ge) begin
        value_nxt = bcast.value;
      end
    end else if (bcast.op_del) begin
      if (hit_out) begin
        value_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign val     = value_r;
  assign val_nxt = value_nxt;

endmodule
